[hw/rtl/bef_pkg.sv]
// Package for the border extension fetch block: sizes, codes and shared types.
// No dependencies; every other design file but bef_ram imports it.
`timescale 1ns / 1ps

package bef_pkg;

  localparam int NUM_DIMS     = 3;
  localparam int MAX_PLANES   = 4;
  localparam int MAX_ROWS     = 128;
  localparam int MAX_COLS     = 128;
  localparam int SAMPLE_WIDTH = 32;

  localparam int PART_W     = 32;
  localparam int WORD_W     = 2 * PART_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  // sizes and borders come from 8-bit registers, so size + border fits 9 bits
  localparam int DIM_W      = 9;

  localparam int DEPTH  = MAX_PLANES * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PI_W   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int RI_W   = $clog2(MAX_ROWS);
  localparam int CI_W   = $clog2(MAX_COLS);

  // largest size a register can express after clamping to the store
  localparam int PLANE_CAP = (MAX_PLANES < 7) ? MAX_PLANES : 7;
  localparam int ROW_CAP   = (MAX_ROWS < 255) ? MAX_ROWS : 255;
  localparam int COL_CAP   = (MAX_COLS < 255) ? MAX_COLS : 255;

  localparam bit DIM0_ON = (NUM_DIMS >= 3);
  localparam bit DIM1_ON = (NUM_DIMS >= 2);

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FILL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EM_PERIODIC = 2'd0,
    EM_WHOLE    = 2'd1,
    EM_HALF     = 2'd2,
    EM_ZERO     = 2'd3
  } edge_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANES  = 3'd0,
    REG_ROWS    = 3'd1,
    REG_COLS    = 3'd2,
    REG_BPLANES = 3'd3,
    REG_BROWS   = 3'd4,
    REG_BCOLS   = 3'd5,
    REG_EDGE    = 3'd6
  } cfg_reg_t;

  // effective geometry after clamping
  typedef struct packed {
    logic [DIM_W-1:0] size_p;
    logic [DIM_W-1:0] size_r;
    logic [DIM_W-1:0] size_c;
    logic [DIM_W-1:0] bord_p;
    logic [DIM_W-1:0] bord_r;
    logic [DIM_W-1:0] bord_c;
    edge_mode_t       mode;
  } geom_t;

  // decoded transaction waiting for the store access
  typedef struct packed {
    logic              is_rd;
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } st1_t;

endpackage

[hw/rtl/border_extension_fetch_core.sv]
// Top level of the border extension fetch block: stream ports, pipeline control,
// sample store. Depends on bef_pkg, bef_cfg, bef_addr and bef_ram.
//
// Usage:
//   in_*  : one transaction per item. in_tuser = 0 stores an origin sample at the
//           coordinate, in_tuser = 1 reads the extended array at the coordinate.
//   out_* : exactly one result per input transaction, in order. out_tuser carries
//           the status (ok, zero fill, coordinate out of range); out_tdata holds
//           the sample for an ok read and zero otherwise.
//   cfg_* : register writes, taken at any edge with cfg_we high; write only while
//           no transaction is in flight.
// Path: an accepted item loads the fold/address register; the store read issues
//   when the item advances to the output stage, where it is offered on out_*.
// Throughput: one item per cycle unless out_tready stalls, set by the single read
//   and write port of the store; writes and reads are issued in order from the same stage.
// Stall: a held result keeps the store read data frozen; up to two items sit in
//   the pipe, and in_tready drops once both stages are full and out_tready is low.
// Reset: clears pipeline valid bits and sets configuration to its defaults; the store
//   is not cleared, and reading a never-written entry returns unspecified data. No reset sweep.
`timescale 1ns / 1ps

module border_extension_fetch_core
  import bef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] coord_plane, [10:3] coord_row, [18:11] coord_col,
  // [50:19] in_re, [82:51] in_im, [87:83] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] out_re, [63:32] out_im
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]            out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  geom_t             geom;
  st1_t              st1;
  logic              v1_r, v1_nxt, v2_r, v2_nxt;
  status_t           st2_status_r;
  logic              st2_rd_r;
  logic              adv1, adv2, load;
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_rdata;

  bef_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  bef_addr u_addr (
    .clk         (clk),
    .load        (load),
    .geom        (geom),
    .is_rd       (in_tuser[0]),
    .coord_plane (in_tdata[2:0]),
    .coord_row   (in_tdata[10:3]),
    .coord_col   (in_tdata[18:11]),
    .in_re       (in_tdata[50:19]),
    .in_im       (in_tdata[82:51]),
    .st1         (st1)
  );

  bef_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (st1.addr),
    .wdata (st1.wdata),
    .re    (ram_re),
    .raddr (st1.addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    adv2   = !v2_r || out_tready;
    adv1   = !v1_r || adv2;
    load   = in_tvalid && adv1;
    ram_we = v1_r && adv2 && !st1.is_rd && (st1.status == ST_OK);
    ram_re = v1_r && adv2 && st1.is_rd && (st1.status == ST_OK);
    v1_nxt = adv1 ? in_tvalid : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && adv2) begin
      st2_status_r <= st1.status;
      st2_rd_r     <= st1.is_rd;
    end
  end

  assign in_tready  = adv1;
  assign out_tvalid = v2_r;
  assign out_tuser  = st2_status_r;
  assign out_tdata  = (st2_rd_r && st2_status_r == ST_OK) ? ram_rdata : '0;

  // one store port pair, one access per transaction
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write issued together");

  // a held ok read must keep its store data
  a_hold_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && st2_rd_r) |=> $stable(ram_rdata))
    else $error("store read data changed under a stalled result");

  // anything but an ok read carries zero parts
  a_zero_parts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK || !st2_rd_r)) |-> (out_tdata == '0))
    else $error("nonzero parts on a write, fill or range result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");

  // store access only for an item that advances to the output stage
  a_access_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we || ram_re) |=> v2_r)
    else $error("store access without a result behind it");

endmodule

[hw/rtl/bef_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bef_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bef_cfg.sv]
// Configuration registers and the clamped geometry derived from them.
// Depends on bef_pkg.
`timescale 1ns / 1ps

module bef_cfg
  import bef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output geom_t                 geom
);

  logic [2:0] planes_r, bplanes_r;
  logic [7:0] rows_r, cols_r, brows_r, bcols_r;
  logic [1:0] edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r  <= 3'd1;
      rows_r    <= 8'd128;
      cols_r    <= 8'd128;
      bplanes_r <= 3'd0;
      brows_r   <= 8'd0;
      bcols_r   <= 8'd0;
      edge_r    <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANES:  planes_r  <= cfg_wdata[2:0];
        REG_ROWS:    rows_r    <= cfg_wdata;
        REG_COLS:    cols_r    <= cfg_wdata;
        REG_BPLANES: bplanes_r <= cfg_wdata[2:0];
        REG_BROWS:   brows_r   <= cfg_wdata;
        REG_BCOLS:   bcols_r   <= cfg_wdata;
        REG_EDGE:    edge_r    <= cfg_wdata[1:0];
        default: ;  // index beyond the register list
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] eff_size(input logic [7:0] raw, input int cap,
                                                input logic on);
    logic [DIM_W-1:0] s;
    begin
      if (!on || raw == 8'd0) s = DIM_W'(1);
      else if (int'(raw) > cap) s = DIM_W'(cap);
      else s = {1'b0, raw};
      return s;
    end
  endfunction

  function automatic logic [DIM_W-1:0] eff_border(input logic [7:0] raw,
                                                  input logic [DIM_W-1:0] s,
                                                  input logic on);
    logic [DIM_W-1:0] b;
    begin
      b = {1'b0, raw};
      if (!on) b = '0;
      else if (b > s) b = s;
      return b;
    end
  endfunction

  always_comb begin
    geom.size_p = eff_size({5'd0, planes_r}, PLANE_CAP, DIM0_ON);
    geom.size_r = eff_size(rows_r, ROW_CAP, DIM1_ON);
    geom.size_c = eff_size(cols_r, COL_CAP, 1'b1);
    geom.bord_p = eff_border({5'd0, bplanes_r}, geom.size_p, DIM0_ON);
    geom.bord_r = eff_border(brows_r, geom.size_r, DIM1_ON);
    geom.bord_c = eff_border(bcols_r, geom.size_c, 1'b1);
    geom.mode   = edge_mode_t'(edge_r);
  end

endmodule

[hw/rtl/bef_addr.sv]
// Coordinate folding, range checks and store address generation, registered.
// Depends on bef_pkg.
`timescale 1ns / 1ps

module bef_addr
  import bef_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  geom_t             geom,
  input  logic              is_rd,
  input  logic [2:0]        coord_plane,
  input  logic [7:0]        coord_row,
  input  logic [7:0]        coord_col,
  input  logic [PART_W-1:0] in_re,
  input  logic [PART_W-1:0] in_im,
  output st1_t              st1
);

  st1_t st1_r, st1_nxt;

  // returns {fill, index}; index is clamped into the origin
  function automatic logic [DIM_W:0] fold(input logic [DIM_W-1:0] c,
                                          input logic [DIM_W-1:0] s,
                                          input logic [DIM_W-1:0] b,
                                          input edge_mode_t md);
    logic signed [DIM_W:0] p, n, q;
    logic                  fill;
    begin
      p    = $signed({1'b0, c}) - $signed({2'b00, b[DIM_W-1:1]});
      n    = $signed({1'b0, s});
      q    = p;
      fill = 1'b0;
      unique case (md)
        EM_PERIODIC: begin
          if (p < 0) q = p + n;
          else if (p >= n) q = p - n;
        end
        EM_WHOLE: begin
          if (p < 0) q = -p;
          else if (p >= n) q = (n <<< 1) - 10'sd2 - p;
        end
        EM_HALF: begin
          if (p < 0) q = -p - 10'sd1;
          else if (p >= n) q = (n <<< 1) - 10'sd1 - p;
        end
        EM_ZERO: begin
          fill = (p < 0) || (p >= n);
        end
      endcase
      // single-sample mirror can land outside the origin
      if (q < 0) q = '0;
      if (q > n - 10'sd1) q = n - 10'sd1;
      return {fill, q[DIM_W-1:0]};
    end
  endfunction

  function automatic logic [PART_W-1:0] sat_part(input logic [PART_W-1:0] v);
    logic signed [PART_W-1:0] x, mx, mn;
    begin
      x = $signed(v);
      if (SAMPLE_WIDTH < PART_W) begin
        mx = PART_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
        mn = -mx - PART_W'(1);
        if (x > mx) x = mx;
        if (x < mn) x = mn;
      end
      return x;
    end
  endfunction

  logic [DIM_W-1:0] cp, cr, cc;
  logic [DIM_W:0]   fp, fr, fc;
  logic             rd_oor, wr_oor;
  logic [PI_W-1:0]  pi;
  logic [RI_W-1:0]  ri;
  logic [CI_W-1:0]  ci;

  always_comb begin
    cp = DIM0_ON ? {6'd0, coord_plane} : '0;
    cr = DIM1_ON ? {1'b0, coord_row} : '0;
    cc = {1'b0, coord_col};

    rd_oor = (cp >= geom.size_p + geom.bord_p) || (cr >= geom.size_r + geom.bord_r) ||
             (cc >= geom.size_c + geom.bord_c);
    wr_oor = (cp >= geom.size_p) || (cr >= geom.size_r) || (cc >= geom.size_c);

    fp = fold(cp, geom.size_p, geom.bord_p, geom.mode);
    fr = fold(cr, geom.size_r, geom.bord_r, geom.mode);
    fc = fold(cc, geom.size_c, geom.bord_c, geom.mode);

    if (is_rd) begin
      pi = PI_W'(fp[DIM_W-1:0]);
      ri = RI_W'(fr[DIM_W-1:0]);
      ci = CI_W'(fc[DIM_W-1:0]);
    end else begin
      pi = PI_W'(cp);
      ri = RI_W'(cr);
      ci = CI_W'(cc);
    end

    st1_nxt.is_rd = is_rd;
    if (is_rd) begin
      if (rd_oor) st1_nxt.status = ST_RANGE;
      else if (fp[DIM_W] || fr[DIM_W] || fc[DIM_W]) st1_nxt.status = ST_FILL;
      else st1_nxt.status = ST_OK;
    end else begin
      st1_nxt.status = wr_oor ? ST_RANGE : ST_OK;
    end
    st1_nxt.addr  = ADDR_W'(pi) * ADDR_W'(MAX_ROWS * MAX_COLS) +
                    ADDR_W'(ri) * ADDR_W'(MAX_COLS) + ADDR_W'(ci);
    st1_nxt.wdata = {sat_part(in_im), sat_part(in_re)};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st1_r <= st1_nxt;
    end
  end

  assign st1 = st1_r;

endmodule
